>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/maf_pkg.sv
// shared types and constants of the moving average filter
// no dependencies
package maf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WIN_CFG_BITS = 6;
  localparam int WIN_RESET = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } maf_state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_step;
    logic out_load;
  } maf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } maf_status_t;

endpackage

>>> rtl/maf_if.sv
// request channels of the moving average filter
// depends on maf_pkg
interface maf_sample_if;
  logic valid;
  logic ready;
  logic [maf_pkg::SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface maf_result_if;
  logic valid;
  logic ready;
  logic [maf_pkg::SAMPLE_BITS-1:0] average;
  logic full_res;
  modport source (output valid, output average, output full_res, input ready);
  modport sink (input valid, input average, input full_res, output ready);
endinterface

>>> rtl/maf_ctrl.sv
// sequencer of the moving average filter
// depends on maf_pkg
module maf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 samp_valid,
  output logic                 samp_ready,
  input  maf_pkg::maf_status_t status,
  output maf_pkg::maf_cmd_t    cmd
);

  maf_pkg::maf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    samp_ready = 1'b0;
    case (state)
      maf_pkg::ST_IDLE: begin
        samp_ready = 1'b1;
        if (samp_valid) begin
          cmd.capture = 1'b1;
          state_next = maf_pkg::ST_LOAD;
        end
      end
      maf_pkg::ST_LOAD: begin
        cmd.update = 1'b1;
        state_next = maf_pkg::ST_DIV;
      end
      maf_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = maf_pkg::ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      maf_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = maf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = maf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/maf_dp.sv
// history memory, running sum, window control, serial divider, output register
// depends on maf_pkg
module maf_dp #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [maf_pkg::WIN_CFG_BITS-1:0] wr_data,
  input  logic [maf_pkg::SAMPLE_BITS-1:0]  sample,
  input  maf_pkg::maf_cmd_t                cmd,
  output maf_pkg::maf_status_t             status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [maf_pkg::SAMPLE_BITS-1:0]  average,
  output logic                             full_res
);

  localparam int SB    = maf_pkg::SAMPLE_BITS;
  localparam int DIV_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SB + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int WIN_INIT = (maf_pkg::WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : maf_pkg::WIN_RESET;

  logic [SB-1:0]    hist [MAX_WINDOW];
  logic [SB-1:0]    hist_rd;
  logic [SB-1:0]    smp;
  logic [DIV_W-1:0] win;
  logic [DIV_W-1:0] pos;
  logic [SUM_W-1:0] sum;
  logic             full;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] rem;
  logic [SUM_W-1:0] dq;
  logic [CNT_W-1:0] cnt;

  logic [IDX_W-1:0] slot;
  logic [DIV_W-1:0] pos_inc;
  logic             wrap;
  logic [SUM_W-1:0] sum_next;
  logic [DIV_W-1:0] win_next;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign slot    = pos[IDX_W-1:0];
  assign pos_inc = pos + DIV_W'(1);
  assign wrap    = (pos_inc >= win);
  // oldest sample leaves only once the window is full
  assign sum_next = sum - (full ? SUM_W'(hist_rd) : SUM_W'(0)) + SUM_W'(smp);

  always_comb begin
    win_next = DIV_W'(wr_data);
    if (wr_data == '0) begin
      win_next = DIV_W'(1);
    end else if (int'(wr_data) > MAX_WINDOW) begin
      win_next = DIV_W'(MAX_WINDOW);
    end
  end

  // one quotient bit per step
  assign trial = {rem, dq[SUM_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp <= sample;
      hist_rd <= hist[slot];
    end
    if (cmd.update) begin
      hist[slot] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= DIV_W'(WIN_INIT);
      pos <= '0;
      sum <= '0;
      full <= 1'b0;
    end else if (wr_en) begin
      win <= win_next;
      pos <= '0;
      sum <= '0;
      full <= 1'b0;
    end else if (cmd.update) begin
      sum <= sum_next;
      pos <= wrap ? '0 : pos_inc;
      if (wrap) begin
        full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.update) begin
      cnt <= CNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      dq <= sum_next;
      rem <= '0;
      divisor <= full ? win : pos_inc;
    end else if (cmd.div_step) begin
      dq <= {dq[SUM_W-2:0], ge};
      rem <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average <= dq[SB-1:0];
      full_res <= full;
    end
  end

  assign status.div_done = (cnt == '0);
  assign status.out_busy = out_valid && !out_ready;

endmodule

>>> rtl/moving_average_filter.sv
// top level of the boxcar moving average filter
// depends on maf_pkg, maf_if, maf_ctrl, maf_dp
//
//   channel  role   payload                        request taken when
//   samp     sink   sample[11:0]                   samp.valid && samp.ready
//   res      source average[11:0], full_res        res.valid && res.ready
//   wr_*     cfg    wr_data[5:0], window length    wr_en high
//
// each request passes these steps, and the next is not taken until it ends: the
// accept step captures the sample and reads the history memory, the load step
// updates the running sum and window position, the restoring divider makes one
// step per sum bit (17 at MAX_WINDOW = 32) and then sees its step count at zero,
// and the hand-off step loads the result register.
// reset and a window length write clear the sum, position and full flag; the
// history memory is not cleared, only slots written first feed the sum.
// the result register holds a finished result while the next request is taken;
// a result that cannot leave stalls only the final step.
module moving_average_filter #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  maf_sample_if.sink                       samp,
  maf_result_if.source                     res,
  input  logic                             wr_en,
  input  logic [maf_pkg::WIN_CFG_BITS-1:0] wr_data
);

  // command and status between sequencer and datapath
  maf_pkg::maf_cmd_t    cmd;
  maf_pkg::maf_status_t status;

  // sequencer: idle, load, divide, hand off
  maf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp.valid),
    .samp_ready (samp.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: memory, sum, divider and result register
  maf_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .sample    (samp.sample),
    .cmd       (cmd),
    .status    (status),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .average   (res.average),
    .full_res  (res.full_res)
  );

endmodule

>>> rtl/maf_checker.sv
// port-level checks of the moving average filter, bound to the top level
// depends on maf_pkg and assert_macros.svh
`include "assert_macros.svh"

module maf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            samp_valid,
  input logic                            samp_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [maf_pkg::SAMPLE_BITS-1:0] res_average,
  input logic                            res_full_res
);

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_average) && $stable(res_full_res), "stalled result changed")
  `ASSERT_NEXT(a_busy_after_take, clk, rst, samp_valid && samp_ready, !samp_ready, "request taken while busy")
  `ASSERT_IMPL(a_ready_fall, clk, rst, $fell(samp_ready), $past(samp_valid), "ready fell without a request")
  `ASSERT_IMPL(a_result_done, clk, rst, $rose(res_valid), samp_ready, "result shown while still busy")

endmodule

bind moving_average_filter maf_checker u_maf_checker (
  .clk          (clk),
  .rst          (rst),
  .samp_valid   (samp.valid),
  .samp_ready   (samp.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_average  (res.average),
  .res_full_res (res.full_res)
);
